/* hw/rtl/pt64_pkg.sv */
// ----------------------------------------------------------------------------
// pt64_pkg
// Shared constants, types and the witness table of the primality tester.
// ----------------------------------------------------------------------------
package pt64_pkg;

  localparam int NUM_BITS_DEF = 64;
  localparam int NUM_WIT = 12;
  localparam int WIT_W = 6;
  localparam int WIDX_W = 4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_WIT,
    ST_RED,
    ST_POW_SQ,
    ST_POW_MUL,
    ST_CHECK,
    ST_SQ,
    ST_SQ_CHK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
  } mm_ctl_t;

  function automatic logic [WIT_W-1:0] witness(input logic [WIDX_W-1:0] k);
    case (k)
      4'd0:    witness = 6'd2;
      4'd1:    witness = 6'd3;
      4'd2:    witness = 6'd5;
      4'd3:    witness = 6'd7;
      4'd4:    witness = 6'd11;
      4'd5:    witness = 6'd13;
      4'd6:    witness = 6'd17;
      4'd7:    witness = 6'd19;
      4'd8:    witness = 6'd23;
      4'd9:    witness = 6'd29;
      4'd10:   witness = 6'd31;
      4'd11:   witness = 6'd37;
      default: witness = 6'd2;
    endcase
  endfunction

endpackage

/* hw/rtl/pt64_mulmod.sv */
// ----------------------------------------------------------------------------
// pt64_mulmod
// Bit-serial modular multiplier: one bit of b per cycle, double and add mod n.
// ----------------------------------------------------------------------------
module pt64_mulmod #(
  parameter int NUM_BITS = pt64_pkg::NUM_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUM_BITS-1:0] a,
  input  logic [NUM_BITS-1:0] b,
  input  logic [NUM_BITS-1:0] n,
  output pt64_pkg::mm_ctl_t   ctl,
  output logic [NUM_BITS-1:0] prod
);
  localparam int CNT_W = $clog2(NUM_BITS + 1);

  logic [NUM_BITS-1:0] acc, acc_next, bsh, av;
  logic [CNT_W-1:0]    cnt;
  logic                busy;
  logic [NUM_BITS:0]   dbl, dred, sum;
  logic [NUM_BITS-1:0] dv;

  // Double, reduce, then conditionally add and reduce.
  always_comb begin
    dbl  = {acc, 1'b0};
    dred = (dbl >= {1'b0, n}) ? dbl - {1'b0, n} : dbl;
    dv   = dred[NUM_BITS-1:0];
    sum  = {1'b0, dv} + {1'b0, av};
    if (bsh[NUM_BITS-1]) begin
      acc_next = (sum >= {1'b0, n}) ? NUM_BITS'(sum - {1'b0, n}) : sum[NUM_BITS-1:0];
    end else begin
      acc_next = dv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NUM_BITS);
      acc  <= '0;
      bsh  <= b;
      av   <= a;
    end else if (busy) begin
      acc <= acc_next;
      bsh <= {bsh[NUM_BITS-2:0], 1'b0};
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign prod      = acc;
  assign ctl.start = start;
  assign ctl.busy  = busy;

  assert property (@(posedge clk) disable iff (rst) busy |-> acc < n || n == '0)
    else $error("accumulator left its residue range");
  assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("multiplier did not start");
  assert property (@(posedge clk) disable iff (rst) busy && cnt == CNT_W'(1) |=> !busy)
    else $error("multiplier ran past its last bit");
endmodule

/* hw/rtl/primality_test_64bit.sv */
// ----------------------------------------------------------------------------
// primality_test_64bit
// Deterministic Miller-Rabin test of one candidate word with witnesses 2..37.
// ----------------------------------------------------------------------------
// Each modular product runs in the bit-serial multiplier (start, one serial step
// per bit of b, capture); a witness needs at most about 2*NUM_BITS products for
// a^d and the squarings after it; small or even words finish far sooner.
// One word is in flight at a time; the result word is held until taken.
// Synchronous active-high reset returns the sequencer to idle, outputs empty.
module primality_test_64bit #(
  parameter int NUM_BITS = pt64_pkg::NUM_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] candidate,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        is_prime
);
  localparam int R_W = $clog2(NUM_BITS + 1);

  pt64_pkg::state_t st, st_next;

  // Working registers: n, odd part d, exponent shift copy, base, accumulator.
  logic [NUM_BITS-1:0] n, d, e, base, x, nm1;
  logic [R_W-1:0]      r, i;
  logic [pt64_pkg::WIDX_W-1:0] k;
  logic [NUM_BITS-1:0] m_a, m_b, prod;
  logic                m_start, m_go, m_go_next, mm_done, verdict;
  pt64_pkg::mm_ctl_t   mctl;
  logic [pt64_pkg::WIT_W-1:0] wv;
  logic [NUM_BITS-1:0] wext;

  assign nm1  = n - 1'b1;
  assign wv   = pt64_pkg::witness(k);
  assign wext = NUM_BITS'(wv);
  assign in_ready = (st == pt64_pkg::ST_IDLE) && !out_valid;

  pt64_mulmod #(.NUM_BITS(NUM_BITS)) u_mm (
    .clk(clk), .rst(rst), .start(m_start), .a(m_a), .b(m_b), .n(n),
    .ctl(mctl), .prod(prod)
  );

  // The multiplier is started once on entry to a product state; m_go marks that.
  assign m_start = m_go && !mctl.busy;
  // A product is ready once the start pulse is gone and the multiplier is idle.
  assign mm_done = !m_go && !mctl.busy;

  always_comb begin
    st_next = st;
    m_a = x;
    m_b = x;
    case (st)
      pt64_pkg::ST_POW_MUL: begin
        m_a = x;
        m_b = base;
      end
      pt64_pkg::ST_POW_SQ: begin
        m_a = base;
        m_b = base;
      end
      default: begin
        m_a = x;
        m_b = x;
      end
    endcase
    case (st)
      pt64_pkg::ST_IDLE: begin
        if (in_valid && in_ready) st_next = pt64_pkg::ST_SPLIT;
      end
      pt64_pkg::ST_SPLIT: begin
        if (n < NUM_BITS'(2)) begin
          st_next = pt64_pkg::ST_DONE;
        end else if (d == '0 || d[0]) begin
          st_next = pt64_pkg::ST_WIT;
        end
      end
      pt64_pkg::ST_WIT: begin
        if (k == pt64_pkg::WIDX_W'(pt64_pkg::NUM_WIT) || n == wext) begin
          st_next = pt64_pkg::ST_DONE;
        end else begin
          st_next = pt64_pkg::ST_RED;
        end
      end
      pt64_pkg::ST_RED: begin
        if (base < n) st_next = d[0] ? pt64_pkg::ST_POW_MUL : pt64_pkg::ST_POW_SQ;
      end
      pt64_pkg::ST_POW_MUL: begin
        if (mm_done) st_next = pt64_pkg::ST_POW_SQ;
      end
      pt64_pkg::ST_POW_SQ: begin
        if (mm_done) begin
          if (e[NUM_BITS-1:1] == '0) begin
            st_next = pt64_pkg::ST_CHECK;
          end else begin
            st_next = e[1] ? pt64_pkg::ST_POW_MUL : pt64_pkg::ST_POW_SQ;
          end
        end
      end
      pt64_pkg::ST_CHECK: begin
        if (x == NUM_BITS'(1) || x == nm1) begin
          st_next = pt64_pkg::ST_WIT;
        end else if (r <= R_W'(1)) begin
          st_next = pt64_pkg::ST_DONE;
        end else begin
          st_next = pt64_pkg::ST_SQ;
        end
      end
      pt64_pkg::ST_SQ: begin
        if (mm_done) st_next = pt64_pkg::ST_SQ_CHK;
      end
      pt64_pkg::ST_SQ_CHK: begin
        if (x == nm1) begin
          st_next = pt64_pkg::ST_WIT;
        end else if (i >= r) begin
          st_next = pt64_pkg::ST_DONE;
        end else begin
          st_next = pt64_pkg::ST_SQ;
        end
      end
      pt64_pkg::ST_DONE: st_next = pt64_pkg::ST_IDLE;
      default: st_next = pt64_pkg::ST_IDLE;
    endcase
    // A new product starts whenever a product state is entered or re-entered.
    m_go_next = (st_next inside {pt64_pkg::ST_POW_MUL, pt64_pkg::ST_POW_SQ,
                                 pt64_pkg::ST_SQ}) && (st_next != st || mm_done);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= pt64_pkg::ST_IDLE;
      out_valid <= 1'b0;
      m_go      <= 1'b0;
    end else begin
      st   <= st_next;
      m_go <= m_go_next;
      if (st == pt64_pkg::ST_DONE) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (st)
      pt64_pkg::ST_IDLE: begin
        if (in_valid && in_ready) begin
          n <= candidate[NUM_BITS-1:0];
          d <= candidate[NUM_BITS-1:0] - 1'b1;
          r <= '0;
          k <= '0;
        end
      end
      pt64_pkg::ST_SPLIT: begin
        // Strip one factor of two per cycle from n-1.
        if (n < NUM_BITS'(2)) begin
          verdict <= 1'b0;
        end else if (d != '0 && !d[0]) begin
          d <= d >> 1;
          r <= r + 1'b1;
        end
      end
      pt64_pkg::ST_WIT: begin
        if (k == pt64_pkg::WIDX_W'(pt64_pkg::NUM_WIT) || n == wext) begin
          verdict <= 1'b1;
        end else begin
          base <= wext;
        end
      end
      pt64_pkg::ST_RED: begin
        // The witness is below 64, so a few subtractions reduce it mod n.
        if (base >= n) begin
          base <= base - n;
        end else begin
          x <= (n == NUM_BITS'(1)) ? '0 : NUM_BITS'(1);
          e <= d;
        end
      end
      pt64_pkg::ST_POW_MUL: begin
        if (mm_done) x <= prod;
      end
      pt64_pkg::ST_POW_SQ: begin
        if (mm_done) begin
          base <= prod;
          e <= e >> 1;
        end
      end
      pt64_pkg::ST_CHECK: begin
        i <= R_W'(1);
        if (x == NUM_BITS'(1) || x == nm1) begin
          k <= k + 1'b1;
        end else if (r <= R_W'(1)) begin
          verdict <= 1'b0;
        end
      end
      pt64_pkg::ST_SQ: begin
        if (mm_done) begin
          x <= prod;
          i <= i + 1'b1;
        end
      end
      pt64_pkg::ST_SQ_CHK: begin
        if (x == nm1) begin
          k <= k + 1'b1;
        end else if (i >= r) begin
          verdict <= 1'b0;
        end
      end
      pt64_pkg::ST_DONE: begin
        is_prime <= verdict;
      end
      default: begin
        verdict <= verdict;
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) in_valid && in_ready |=> !out_valid)
    else $error("result shown while a word was just taken");
  assert property (@(posedge clk) disable iff (rst) out_valid && !out_ready |=> out_valid)
    else $error("result word dropped before it was taken");
  assert property (@(posedge clk) disable iff (rst)
      st == pt64_pkg::ST_DONE |=> out_valid && st == pt64_pkg::ST_IDLE)
    else $error("finished test did not post its result");
endmodule

/* tb/sv/primality_test_64bit_tb.sv */
// ----------------------------------------------------------------------------
// primality_test_64bit_tb
// Drives candidate words into the primality tester, predicts each verdict
// with an independent Miller-Rabin model and compares every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module primality_test_64bit_tb;

  localparam int NBITS = 64;
  // Allow for a worst-case word plus a long receiver stall on top.
  localparam int IDLE_LIMIT = 1000000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] candidate;
  logic        out_valid;
  logic        out_ready;
  logic        is_prime;

  // Verdicts still owed by the block, oldest first.
  bit          verdict_q[$];
  int          mismatch_cnt;
  int          stall_cycles;
  bit          timed_out;

  primality_test_64bit #(.NUM_BITS(NBITS)) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .candidate (candidate),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .is_prime  (is_prime)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Gap length: mostly zero or short, now and then long.
  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return 0;
    if (sel < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  // Modular product built from the exact 128-bit product.
  function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b,
                                         logic [63:0] n);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return 64'((p % {64'd0, n}));
  endfunction

  function automatic logic [63:0] powmod(logic [63:0] base, logic [63:0] e,
                                         logic [63:0] n);
    logic [63:0] acc;
    logic [63:0] b;
    acc = 64'd1 % n;
    b = base % n;
    while (e != 0) begin
      if (e[0]) acc = mulmod(acc, b, n);
      b = mulmod(b, b, n);
      e = e >> 1;
    end
    return acc;
  endfunction

  // Expected verdict for one candidate word, trying witnesses 2..37 in order.
  function automatic bit predict_prime(logic [63:0] raw);
    logic [63:0] n;
    logic [63:0] d;
    logic [63:0] x;
    logic [63:0] a;
    int          r;
    bit          saved;
    n = (NBITS == 64) ? raw : (raw & ((64'd1 << NBITS) - 1));
    if (n < 2) return 1'b0;
    d = n - 1;
    r = 0;
    while (d != 0 && !d[0]) begin
      d = d >> 1;
      r++;
    end
    for (int k = 0; k < pt64_pkg::NUM_WIT; k++) begin
      a = 64'(pt64_pkg::witness(pt64_pkg::WIDX_W'(k)));
      if (n == a) return 1'b1;
      x = powmod(a, d, n);
      saved = (x == 1) || (x == n - 1);
      for (int i = 1; i < r && !saved; i++) begin
        x = mulmod(x, x, n);
        if (x == n - 1) saved = 1'b1;
      end
      if (!saved) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Sends one candidate word and records its expected verdict on acceptance.
  // Valid stays high into the next word when there is no gap.
  task automatic send_word(logic [63:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid  <= 1'b0;
      candidate <= $urandom;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    candidate <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    verdict_q = {verdict_q, predict_prime(value)};
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  // Receiver: random back-pressure and comparison of each result word.
  initial begin
    bit expv;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected result word: is_prime=%0b", is_prime);
        end else begin
          expv = verdict_q.pop_front();
          if (is_prime !== expv) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("is_prime mismatch: expected %0b actual %0b", expv, is_prime);
          end
        end
      end
      out_ready <= ($urandom_range(0, 9) < 7) ? 1'b1 : (pick_gap() == 0);
    end
  end

  // Watchdog: counts cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= IDLE_LIMIT && !timed_out) begin
        timed_out <= 1'b1;
        $display("** primality_test_64bit: FAILED **");
        $finish;
      end
    end
  end

  task automatic test_edges();
    send_word(64'd0);
    send_word(64'd1);
    send_word(64'd2);
    send_word(64'd3);
    send_word(64'd4);
    send_word(64'hFFFF_FFFF_FFFF_FFFF);     // odd composite, all ones
    send_word(64'hFFFF_FFFF_FFFF_FFC5);     // largest 64-bit prime
    send_word(64'h8000_0000_0000_0000);     // top bit only, even
  endtask

  task automatic test_witnesses();
    // Each witness value itself, plus small composites below 37.
    for (int k = 0; k < pt64_pkg::NUM_WIT; k++)
      send_word(64'(pt64_pkg::witness(pt64_pkg::WIDX_W'(k))));
    send_word(64'd9);
    send_word(64'd25);
    send_word(64'd35);
  endtask

  task automatic test_pseudoprimes();
    // Strong pseudoprimes to small bases and a Carmichael number.
    send_word(64'd2047);
    send_word(64'd561);
    send_word(64'd3215031751);
    send_word(64'd3825123056546413051);
  endtask

  task automatic test_random();
    logic [63:0] v;
    for (int i = 0; i < 75; i++) begin
      case ($urandom_range(0, 3))
        0: v = 64'($urandom_range(0, 2000));
        1: v = {$urandom, $urandom} | 64'd1;
        2: v = {32'd0, $urandom} | 64'd1;
        default: v = {$urandom, $urandom};
      endcase
      send_word(v);
      // Once midway, hold the sender until the block has emptied.
      if (i == 37) drain();
    end
  endtask

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    candidate <= 64'd0;
    mismatch_cnt = 0;
    stall_cycles = 0;
    timed_out = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_edges();
    test_witnesses();
    test_pseudoprimes();
    test_random();
    drain();
    repeat (50) @(posedge clk);
    if (mismatch_cnt == 0 && verdict_q.size() == 0)
      $display("** primality_test_64bit: PASSED **");
    else
      $display("** primality_test_64bit: FAILED **");
    $finish;
  end

endmodule

/* primality_test_64bit.f */
hw/rtl/pt64_pkg.sv
hw/rtl/pt64_mulmod.sv
hw/rtl/primality_test_64bit.sv
tb/sv/primality_test_64bit_tb.sv
